// ----- design/round_robin_task_scheduler_unit_defines.svh -----
// Assertion macros shared by the scheduler RTL.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define RRTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rrts_pkg.sv -----
// Types, constants and helpers of the round-robin task scheduler.
// No dependencies; used by the interfaces, the task store and the top level.
package rrts_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int TICK_WIDTH = 32;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int SIZE_W     = $clog2(NUM_SLOTS + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] SLICE_RST = 8'd10;
    localparam logic [3:0] IDLE_RST  = 4'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLICE_RELOAD = 1'b0,
        CFG_IDLE_SLOT    = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        M_READY  = 3'd0,
        M_REMOVE = 3'd1,
        M_TICK   = 3'd2,
        M_YIELD  = 3'd3,
        M_EXIT   = 3'd4,
        M_START  = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        TS_NOT_READY = 2'd0,
        TS_READY     = 2'd1,
        TS_RUN       = 2'd2,
        TS_EXIT      = 2'd3
    } t_tstate;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EV_CHK,
        S_RS_BEGIN,
        S_RS_CMP,
        S_RS_PRV,
        S_RS_NXT_RD,
        S_RS_NXT,
        S_UL_RD,
        S_UL_A,
        S_UL_B,
        S_ENQ,
        S_ENQ_B,
        S_FIN,
        S_RES
    } t_state;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] slot;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  current_task;
        logic [3:0]  previous_task;
        logic        switched;
        logic        status;
        logic [4:0]  ready_count;
        logic [31:0] current_ticks;
    } t_out_word;

    typedef struct packed {
        logic                  in_q;
        t_tstate               st;
        logic [7:0]            slice;
        logic [TICK_WIDTH-1:0] ticks;
    } t_task;

    typedef struct packed {
        logic [SLOT_W-1:0] nxt;
        logic [SLOT_W-1:0] prv;
    } t_link;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        t_task             wr_data;
    } t_tm_req;

    localparam t_task TASK_RST = '{in_q: 1'b0, st: TS_NOT_READY, slice: SLICE_RST,
                                   ticks: '0};

    function automatic logic slot_ok(input logic [3:0] s);
        return 32'(s) < 32'(NUM_SLOTS);
    endfunction

    // out-of-table idle slot falls back to the last slot
    function automatic logic [SLOT_W-1:0] idle_of(input logic [3:0] s);
        return slot_ok(s) ? SLOT_W'(s) : SLOT_W'(NUM_SLOTS - 1);
    endfunction

endpackage

// ----- design/rrts_in_if.sv -----
// Event channel of the scheduler: valid, ready and one event word.
// Depends on rrts_pkg.
interface rrts_in_if;
    import rrts_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word word;

    modport source(output valid, output word, input ready);
    modport sink(input valid, input word, output ready);
endinterface

// ----- design/rrts_out_if.sv -----
// Result channel of the scheduler: valid, ready and one result word.
// Depends on rrts_pkg.
interface rrts_out_if;
    import rrts_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word word;

    modport source(output valid, output word, input ready);
    modport sink(input valid, input word, output ready);
endinterface

// ----- design/rrts_task_store.sv -----
// Per-slot task memory: queue flag, task state, slice left and tick total.
// One read and one write port, registered read; valid bits give reset values.
// Depends on rrts_pkg and the defines header.
`include "round_robin_task_scheduler_unit_defines.svh"

module rrts_task_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rrts_pkg::t_tm_req i_req,
    output rrts_pkg::t_task  o_rd_data
);
    import rrts_pkg::*;

    t_task                mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid;
    t_task                r_rd;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd <= mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_valid[i_req.rd_addr];
            end
        end
    end

    // never-written entries read as their reset contents
    assign o_rd_data = r_rd_vld ? r_rd : TASK_RST;

    `RRTS_ASSERT_NEXT(a_wr_sets_valid, i_req.wr_en, r_valid[$past(i_req.wr_addr)],
        "task store write did not mark its entry valid")

endmodule

// ----- design/round_robin_task_scheduler_unit.sv -----
// Round-robin task scheduler. One result word per event word. How long an event takes
// depends on its kind: ignored events are the shortest, a ready or remove takes longer,
// and a tick, yield or exit that reschedules the longest, set by the link memory (a queue
// unlink or append makes up to two link writes) and the task memory, which is read and
// written back once per touched slot. A result that is held on the result channel adds
// its stall to the next event. Both memories come up usable at once after
// reset: the task memory keeps a valid bit per slot, the link memory is only read for
// queued slots. The result register lets the next event be taken while a result waits.
// User must write configuration via i_cfg_* while no event is in flight; not enforced.
`include "round_robin_task_scheduler_unit_defines.svh"

module round_robin_task_scheduler_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rrts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rrts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rrts_in_if.sink                        i_in,
    rrts_out_if.source                     o_out
);
    import rrts_pkg::*;

    // control and queue registers
    t_state            r_state, n_state;
    t_state            r_ret, n_ret;
    logic [2:0]        r_mode, n_mode;
    logic [3:0]        r_slot, n_slot;
    logic [SLOT_W-1:0] r_before, n_before;
    logic              r_ign, n_ign;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [SLOT_W-1:0] r_run, n_run;
    logic              r_on, n_on;
    logic [SLOT_W-1:0] r_nxt, n_nxt;
    logic              r_popped, n_popped;
    logic [SLOT_W-1:0] r_ulx, n_ulx;
    logic [SLOT_W-1:0] r_enqx, n_enqx;
    logic [SLOT_W-1:0] r_p, n_p;
    logic [SLOT_W-1:0] r_n, n_n;
    logic              r_is_tail, n_is_tail;
    logic              r_out_vld, n_out_vld;
    t_out_word         r_out, n_out;
    logic [7:0]        r_slice_rl;
    logic [3:0]        r_idle_cfg;

    logic [SLOT_W-1:0] idle_s;
    logic [SLOT_W-1:0] slot_a;
    logic              in_ready;
    logic              in_acc;

    // task memory
    t_tm_req tm_req;
    t_task   td;

    // link memory
    t_link             l_mem [NUM_SLOTS];
    t_link             r_lrd;
    logic              lk_rd_en;
    logic [SLOT_W-1:0] lk_rd_addr;
    logic              lk_wr_nxt;
    logic              lk_wr_prv;
    logic [SLOT_W-1:0] lk_wr_addr;
    t_link             lk_wr_data;

    assign idle_s = idle_of(r_idle_cfg);
    assign slot_a = SLOT_W'(r_slot);
    assign in_acc = i_in.valid && in_ready;

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_vld;
    assign o_out.word  = r_out;

    rrts_task_store u_task_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tm_req),
        .o_rd_data (td)
    );

    always_ff @(posedge i_clk) begin
        if (lk_wr_nxt) begin
            l_mem[lk_wr_addr].nxt <= lk_wr_data.nxt;
        end
        if (lk_wr_prv) begin
            l_mem[lk_wr_addr].prv <= lk_wr_data.prv;
        end
        if (lk_rd_en) begin
            r_lrd <= l_mem[lk_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_rl <= SLICE_RST;
            r_idle_cfg <= IDLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SLICE_RELOAD: r_slice_rl <= i_cfg_data[7:0];
                CFG_IDLE_SLOT:    r_idle_cfg <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_FIN;
            r_head    <= '0;
            r_tail    <= '0;
            r_size    <= '0;
            r_run     <= '0;
            r_on      <= 1'b0;
            r_popped  <= 1'b0;
            r_is_tail <= 1'b0;
            r_ign     <= 1'b1;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_size    <= n_size;
            r_run     <= n_run;
            r_on      <= n_on;
            r_popped  <= n_popped;
            r_is_tail <= n_is_tail;
            r_ign     <= n_ign;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_slot   <= n_slot;
        r_before <= n_before;
        r_nxt    <= n_nxt;
        r_ulx    <= n_ulx;
        r_enqx   <= n_enqx;
        r_p      <= n_p;
        r_n      <= n_n;
        r_out    <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_mode    = r_mode;
        n_slot    = r_slot;
        n_before  = r_before;
        n_ign     = r_ign;
        n_head    = r_head;
        n_tail    = r_tail;
        n_size    = r_size;
        n_run     = r_run;
        n_on      = r_on;
        n_nxt     = r_nxt;
        n_popped  = r_popped;
        n_ulx     = r_ulx;
        n_enqx    = r_enqx;
        n_p       = r_p;
        n_n       = r_n;
        n_is_tail = r_is_tail;
        n_out_vld = r_out_vld;
        n_out     = r_out;

        in_ready       = 1'b0;
        tm_req         = '0;
        tm_req.wr_data = td;
        lk_rd_en       = 1'b0;
        lk_rd_addr     = '0;
        lk_wr_nxt      = 1'b0;
        lk_wr_prv      = 1'b0;
        lk_wr_addr     = '0;
        lk_wr_data     = '0;

        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                // take no word while reset is held
                in_ready = i_rst_n;
                if (i_in.valid) begin
                    n_mode   = i_in.word.mode;
                    n_slot   = i_in.word.slot;
                    n_before = r_run;
                    n_ign    = 1'b1;
                    n_state  = S_FIN;
                    unique case (i_in.word.mode) inside
                        M_READY, M_REMOVE: begin
                            if (slot_ok(i_in.word.slot)) begin
                                tm_req.rd_en   = 1'b1;
                                tm_req.rd_addr = SLOT_W'(i_in.word.slot);
                                n_state        = S_EV_CHK;
                            end
                        end
                        M_TICK, M_YIELD: begin
                            if (r_on) begin
                                tm_req.rd_en   = 1'b1;
                                tm_req.rd_addr = r_run;
                                n_state        = S_EV_CHK;
                            end
                        end
                        M_EXIT: begin
                            if (r_on && r_run != idle_s) begin
                                tm_req.rd_en   = 1'b1;
                                tm_req.rd_addr = r_run;
                                n_state        = S_EV_CHK;
                            end
                        end
                        M_START: begin
                            if (!r_on) begin
                                n_on           = 1'b1;
                                n_run          = idle_s;
                                n_ign          = 1'b0;
                                tm_req.rd_en   = 1'b1;
                                tm_req.rd_addr = idle_s;
                                n_state        = S_EV_CHK;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_EV_CHK: begin
                n_state = S_FIN;
                unique case (r_mode) inside
                    M_READY: begin
                        // a queued or running slot stays as it is
                        if (!td.in_q && td.st != TS_RUN) begin
                            tm_req.wr_en        = 1'b1;
                            tm_req.wr_addr      = slot_a;
                            tm_req.wr_data.in_q = 1'b1;
                            tm_req.wr_data.st   = TS_READY;
                            n_ign               = 1'b0;
                            n_enqx              = slot_a;
                            n_ret               = S_FIN;
                            n_state             = S_ENQ;
                        end
                    end
                    M_REMOVE: begin
                        if (td.in_q) begin
                            tm_req.wr_en        = 1'b1;
                            tm_req.wr_addr      = slot_a;
                            tm_req.wr_data.in_q = 1'b0;
                            n_ign               = 1'b0;
                            n_ulx               = slot_a;
                            n_ret               = S_FIN;
                            n_state             = S_UL_RD;
                        end
                    end
                    M_TICK: begin
                        n_ign                = 1'b0;
                        tm_req.wr_en         = 1'b1;
                        tm_req.wr_addr       = r_run;
                        tm_req.wr_data.ticks = td.ticks + TICK_WIDTH'(1);
                        // a zero slice never expires
                        if (r_run != idle_s && td.slice != 8'd0) begin
                            if (td.slice == 8'd1) begin
                                tm_req.wr_data.slice = r_slice_rl;
                                n_state              = S_RS_BEGIN;
                            end else begin
                                tm_req.wr_data.slice = td.slice - 8'd1;
                            end
                        end
                    end
                    M_YIELD: begin
                        if (td.st == TS_RUN) begin
                            n_ign   = 1'b0;
                            n_state = S_RS_BEGIN;
                        end
                    end
                    M_EXIT: begin
                        n_ign               = 1'b0;
                        tm_req.wr_en        = 1'b1;
                        tm_req.wr_addr      = r_run;
                        tm_req.wr_data.in_q = 1'b0;
                        tm_req.wr_data.st   = TS_EXIT;
                        n_state             = S_RS_BEGIN;
                        if (td.in_q) begin
                            n_ulx   = r_run;
                            n_ret   = S_RS_BEGIN;
                            n_state = S_UL_RD;
                        end
                    end
                    M_START: begin
                        tm_req.wr_en      = 1'b1;
                        tm_req.wr_addr    = idle_s;
                        tm_req.wr_data.st = TS_RUN;
                        if (r_size != '0) begin
                            n_state = S_RS_BEGIN;
                        end
                    end
                    default: ;
                endcase
            end

            S_RS_BEGIN: begin
                // pop the head, or fall back to the idle slot
                if (r_size != '0) begin
                    n_nxt    = r_head;
                    n_popped = 1'b1;
                    n_ulx    = r_head;
                    n_ret    = S_RS_CMP;
                    n_state  = S_UL_RD;
                end else begin
                    n_nxt    = idle_s;
                    n_popped = 1'b0;
                    n_state  = S_RS_CMP;
                end
            end

            S_RS_CMP: begin
                if (r_nxt == r_run) begin
                    if (r_popped) begin
                        tm_req.rd_en   = 1'b1;
                        tm_req.rd_addr = r_nxt;
                        n_state        = S_RS_NXT;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    tm_req.rd_en   = 1'b1;
                    tm_req.rd_addr = r_run;
                    n_state        = S_RS_PRV;
                end
            end

            S_RS_PRV: begin
                n_state = S_RS_NXT_RD;
                // requeue a preempted task at the tail
                if (td.st == TS_RUN && r_run != idle_s) begin
                    tm_req.wr_en        = 1'b1;
                    tm_req.wr_addr      = r_run;
                    tm_req.wr_data.in_q = 1'b1;
                    tm_req.wr_data.st   = TS_READY;
                    n_enqx              = r_run;
                    n_ret               = S_RS_NXT_RD;
                    n_state             = S_ENQ;
                end
            end

            S_RS_NXT_RD: begin
                tm_req.rd_en   = 1'b1;
                tm_req.rd_addr = r_nxt;
                n_state        = S_RS_NXT;
            end

            S_RS_NXT: begin
                tm_req.wr_en   = 1'b1;
                tm_req.wr_addr = r_nxt;
                if (r_popped) begin
                    tm_req.wr_data.in_q = 1'b0;
                end
                if (r_nxt != r_run) begin
                    tm_req.wr_data.st = TS_RUN;
                end
                n_run   = r_nxt;
                n_state = S_FIN;
            end

            S_UL_RD: begin
                lk_rd_en   = 1'b1;
                lk_rd_addr = r_ulx;
                n_state    = S_UL_A;
            end

            S_UL_A: begin
                n_p       = r_lrd.prv;
                n_n       = r_lrd.nxt;
                n_is_tail = (r_ulx == r_tail);
                if (r_ulx != r_head) begin
                    lk_wr_nxt      = 1'b1;
                    lk_wr_addr     = r_lrd.prv;
                    lk_wr_data.nxt = r_lrd.nxt;
                end else begin
                    n_head = r_lrd.nxt;
                end
                if (r_ulx == r_tail) begin
                    n_tail = r_lrd.prv;
                end
                n_size = r_size - SIZE_W'(1);
                // an emptied queue parks head and tail at slot zero
                if (r_size == SIZE_W'(1)) begin
                    n_head = '0;
                    n_tail = '0;
                end
                n_state = S_UL_B;
            end

            S_UL_B: begin
                if (!r_is_tail) begin
                    lk_wr_prv      = 1'b1;
                    lk_wr_addr     = r_n;
                    lk_wr_data.prv = r_p;
                end
                n_state = r_ret;
            end

            S_ENQ: begin
                if (r_size == '0) begin
                    n_head  = r_enqx;
                    n_tail  = r_enqx;
                    n_size  = r_size + SIZE_W'(1);
                    n_state = r_ret;
                end else begin
                    lk_wr_nxt      = 1'b1;
                    lk_wr_addr     = r_tail;
                    lk_wr_data.nxt = r_enqx;
                    n_state        = S_ENQ_B;
                end
            end

            S_ENQ_B: begin
                lk_wr_prv      = 1'b1;
                lk_wr_addr     = r_enqx;
                lk_wr_data.prv = r_tail;
                n_tail         = r_enqx;
                n_size         = r_size + SIZE_W'(1);
                n_state        = r_ret;
            end

            S_FIN: begin
                tm_req.rd_en   = 1'b1;
                tm_req.rd_addr = r_run;
                n_state        = S_RES;
            end

            S_RES: begin
                // hold until the result register is free
                if (!r_out_vld || o_out.ready) begin
                    n_out.current_task  = 4'(r_run);
                    n_out.previous_task = 4'(r_before);
                    n_out.switched      = (r_run != r_before);
                    n_out.status        = r_ign;
                    n_out.ready_count   = 5'(r_size);
                    n_out.current_ticks = 32'(td.ticks);
                    n_out_vld           = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    `RRTS_ASSERT_NOW(a_tm_no_clash, 1'b1, !(tm_req.rd_en && tm_req.wr_en),
        "task memory read and write in the same cycle")
    `RRTS_ASSERT_NOW(a_lk_no_clash, lk_rd_en, !(lk_wr_nxt || lk_wr_prv),
        "link memory read and write in the same cycle")
    `RRTS_ASSERT_NEXT(a_accept_busy, in_acc, r_state != S_IDLE,
        "accepted event word left the sequencer idle")
    `RRTS_ASSERT_NOW(a_switch_moves, r_out_vld && r_out.switched,
        r_out.current_task != r_out.previous_task,
        "switch reported without a change of running slot")

endmodule
